/* hw/rtl/host_frame_parser_and_command_decoder_macros.svh */
// Assertion macros for the parser RTL.
`ifndef HOST_FRAME_PARSER_AND_COMMAND_DECODER_MACROS_SVH
`define HOST_FRAME_PARSER_AND_COMMAND_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/hfp_pkg.sv */
`default_nettype none

package hfp_pkg;

	// Default geometry of one picture
	localparam int unsigned ROWS_PER_FRAME_DEF = 32;
	localparam int unsigned BYTES_PER_ROW_DEF  = 8;

	// Frame delimiters and length limits
	localparam logic [7:0]  START_BYTE = 8'hAA;
	localparam logic [7:0]  END_BYTE   = 8'hBB;
	localparam logic [15:0] MIN_LENGTH = 16'd2;
	localparam logic [15:0] MAX_LENGTH = 16'd4096;

	// Field widths
	localparam int unsigned LEN_W      = 13;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned ROW_WORD_W = 64;
	localparam int unsigned CODE_W     = 3;
	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned TDATA_W    = 104;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_ROW    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CMD    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NOTICE = 2'd2;

	// Command codes
	localparam logic [CODE_W-1:0] CMD_START      = 3'd0;
	localparam logic [CODE_W-1:0] CMD_STOP       = 3'd1;
	localparam logic [CODE_W-1:0] CMD_TEST       = 3'd2;
	localparam logic [CODE_W-1:0] CMD_POWER_ON   = 3'd3;
	localparam logic [CODE_W-1:0] CMD_CAM_PULSE  = 3'd4;
	localparam logic [CODE_W-1:0] CMD_VALVE_PULSE = 3'd5;
	localparam logic [CODE_W-1:0] CMD_CAM_TO_VALVE = 3'd6;

	// Two-letter frame types, first letter in the high byte
	localparam logic [15:0] TYPE_DA = 16'h6461;
	localparam logic [15:0] TYPE_ST = 16'h7374;
	localparam logic [15:0] TYPE_SP = 16'h7370;
	localparam logic [15:0] TYPE_TE = 16'h7465;
	localparam logic [15:0] TYPE_PO = 16'h706F;
	localparam logic [15:0] TYPE_SC = 16'h7363;
	localparam logic [15:0] TYPE_SV = 16'h7376;
	localparam logic [15:0] TYPE_SD = 16'h7364;

	typedef struct packed {
		logic              valid;
		logic [CODE_W-1:0] code;
	} cmd_lookup_t;

	// Controller to datapath
	typedef struct packed {
		logic ld_len_hi;
		logic ld_len_lo;
		logic ld_type0;
		logic ld_type1;
		logic pay_byte;
		logic cap_end;
		logic rd_row;
		logic ld_row;
		logic ld_cmd;
		logic ld_note;
	} hfp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic start_ok;
		logic len_bad;
		logic len_zero;
		logic pay_last;
		logic end_ok;
		logic pic_ok;
		logic cmd_ok;
		logic last_row;
		logic note_due;
		logic out_free;
	} hfp_status_t;

	function automatic cmd_lookup_t cmd_lookup(input logic [15:0] type_code);
		cmd_lookup_t r;
		r.valid = 1'b1;
		unique case (type_code)
			TYPE_ST: r.code = CMD_START;
			TYPE_SP: r.code = CMD_STOP;
			TYPE_TE: r.code = CMD_TEST;
			TYPE_PO: r.code = CMD_POWER_ON;
			TYPE_SC: r.code = CMD_CAM_PULSE;
			TYPE_SV: r.code = CMD_VALVE_PULSE;
			TYPE_SD: r.code = CMD_CAM_TO_VALVE;
			default: begin
				r.valid = 1'b0;
				r.code  = CMD_START;
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/host_frame_parser_and_command_decoder.sv */
// Channel  Dir  tdata (low bit up)                             tuser             tlast
// s_*      in   rx_byte[7:0]                                   row_queue_empty   -
// m_*      out  row_word[63:0] command_code[66:64]             kind[1:0]         last_of_run
//                command_value[98:67], zero to bit 103
//
// One byte is taken per cycle while a frame is parsed.
// A good picture frame then emits its rows, each by a store read and then an output
// load, plus an underrun notice if one is due; a good command frame emits one result.
// No byte is taken while results of a frame are being emitted.
// The output register holds a result until m_tready; arst_n clears all control state.
`default_nettype none

module host_frame_parser_and_command_decoder #(
	parameter int unsigned ROWS_PER_FRAME = hfp_pkg::ROWS_PER_FRAME_DEF,
	parameter int unsigned BYTES_PER_ROW  = hfp_pkg::BYTES_PER_ROW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // rx_byte
	input  logic                          s_tuser,   // row_queue_empty
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hfp_pkg::TDATA_W-1:0]   m_tdata,   // row_word, command_code, command_value
	output logic [hfp_pkg::KIND_W-1:0]    m_tuser,   // kind
	output logic                          m_tlast    // last_of_run
);
	import hfp_pkg::*;

	hfp_cmd_t              cmd;
	hfp_status_t           st;
	logic [ROW_WORD_W-1:0] out_row;
	logic [CODE_W-1:0]     out_code;
	logic [VALUE_W-1:0]    out_value;

	hfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	hfp_datapath #(
		.ROWS_PER_FRAME (ROWS_PER_FRAME),
		.BYTES_PER_ROW  (BYTES_PER_ROW)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_byte     (s_tdata),
		.queue_empty (s_tuser),
		.cmd         (cmd),
		.st          (st),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_kind    (m_tuser),
		.out_row     (out_row),
		.out_code    (out_code),
		.out_value   (out_value),
		.out_last    (m_tlast)
	);

	// Pack result fields, first field lowest
	assign m_tdata = {{(TDATA_W - ROW_WORD_W - CODE_W - VALUE_W){1'b0}},
		out_value, out_code, out_row};

endmodule

`default_nettype wire

/* hw/rtl/hfp_datapath.sv */
`default_nettype none
`include "host_frame_parser_and_command_decoder_macros.svh"

module hfp_datapath #(
	parameter int unsigned ROWS_PER_FRAME = hfp_pkg::ROWS_PER_FRAME_DEF,
	parameter int unsigned BYTES_PER_ROW  = hfp_pkg::BYTES_PER_ROW_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [7:0]                      rx_byte,
	input  logic                            queue_empty,
	input  hfp_pkg::hfp_cmd_t               cmd,
	output hfp_pkg::hfp_status_t            st,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [hfp_pkg::KIND_W-1:0]      out_kind,
	output logic [hfp_pkg::ROW_WORD_W-1:0]  out_row,
	output logic [hfp_pkg::CODE_W-1:0]      out_code,
	output logic [hfp_pkg::VALUE_W-1:0]     out_value,
	output logic                            out_last
);
	import hfp_pkg::*;

	localparam int unsigned PIC_BYTES = ROWS_PER_FRAME * BYTES_PER_ROW;
	localparam int unsigned ROW_AW = (ROWS_PER_FRAME > 1) ? $clog2(ROWS_PER_FRAME) : 1;
	localparam int unsigned COL_AW = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef enum logic [1:0] {
		NUM_BEFORE,
		NUM_IN,
		NUM_DONE
	} num_phase_t;

	// Frame header and payload counters
	logic [7:0]          len_hi_q;
	logic [LEN_W-1:0]    frame_len_q;
	logic [LEN_W-1:0]    byte_cnt_q;
	logic [15:0]         type_q;
	logic [ROW_AW-1:0]   wr_row_q;
	logic [COL_AW-1:0]   wr_col_q;
	logic [ROW_AW-1:0]   rd_row_q;

	// Decimal parser
	logic [VALUE_W-1:0]  acc_q;
	num_phase_t          num_ph_q;
	logic                num_neg_q;

	// Underrun bookkeeping
	logic                flag_q;
	logic                note_q;

	// Picture store, one row per entry, byte lanes in arrival order
	logic [BYTES_PER_ROW-1:0][7:0] pic_mem [ROWS_PER_FRAME];
	logic [BYTES_PER_ROW-1:0][7:0] rd_data_q;

	// Output register
	logic                  out_valid_q;
	logic [KIND_W-1:0]     out_kind_q;
	logic [ROW_WORD_W-1:0] out_row_q;
	logic [CODE_W-1:0]     out_code_q;
	logic [VALUE_W-1:0]    out_value_q;
	logic                  out_last_q;

	logic [15:0]           len_full;
	logic [15:0]           len_sub;
	logic [LEN_W-1:0]      cnt_inc;
	logic                  wr_on;
	logic                  is_digit;
	logic                  is_space;
	logic [VALUE_W-1:0]    acc_next;
	logic [ROW_WORD_W-1:0] row_word;
	cmd_lookup_t           lookup;
	logic                  out_free;

	// Header decode
	assign len_full = {len_hi_q, rx_byte};
	assign len_sub  = len_full - MIN_LENGTH;
	assign cnt_inc  = byte_cnt_q + 1'b1;
	assign wr_on    = byte_cnt_q < LEN_W'(PIC_BYTES);
	assign lookup   = cmd_lookup(type_q);
	assign out_free = !out_valid_q || out_ready;

	// Number syntax classes
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign is_space = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
	assign acc_next = (acc_q << 3) + (acc_q << 1) + {24'd0, rx_byte - CH_ZERO};

	// Row word: first received byte most significant
	always_comb begin
		row_word = '0;
		for (int c = 0; c < BYTES_PER_ROW; c++) begin
			row_word[(BYTES_PER_ROW - 1 - c) * 8 +: 8] = rd_data_q[c];
		end
	end

	// Status to controller
	always_comb begin
		st.start_ok = rx_byte == START_BYTE;
		st.len_bad  = (len_full < MIN_LENGTH) || (len_full > MAX_LENGTH);
		st.len_zero = frame_len_q == '0;
		st.pay_last = cnt_inc >= frame_len_q;
		st.end_ok   = rx_byte == END_BYTE;
		st.pic_ok   = (type_q == TYPE_DA) && (frame_len_q == LEN_W'(PIC_BYTES));
		st.cmd_ok   = lookup.valid;
		st.last_row = rd_row_q == ROW_AW'(ROWS_PER_FRAME - 1);
		st.note_due = note_q;
		st.out_free = out_free;
	end

	// Parse registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_hi_q    <= '0;
			frame_len_q <= '0;
			byte_cnt_q  <= '0;
			type_q      <= '0;
			wr_row_q    <= '0;
			wr_col_q    <= '0;
			rd_row_q    <= '0;
			acc_q       <= '0;
			num_ph_q    <= NUM_BEFORE;
			num_neg_q   <= 1'b0;
			flag_q      <= 1'b0;
			note_q      <= 1'b0;
		end else begin
			if (cmd.ld_len_hi) begin
				len_hi_q <= rx_byte;
			end
			if (cmd.ld_len_lo) begin
				frame_len_q <= len_sub[LEN_W-1:0];
			end
			if (cmd.ld_type0) begin
				type_q[15:8] <= rx_byte;
			end
			if (cmd.ld_type1) begin
				type_q[7:0] <= rx_byte;
				byte_cnt_q  <= '0;
				wr_row_q    <= '0;
				wr_col_q    <= '0;
				acc_q       <= '0;
				num_ph_q    <= NUM_BEFORE;
				num_neg_q   <= 1'b0;
			end
			if (cmd.pay_byte) begin
				byte_cnt_q <= cnt_inc;
				if (wr_on) begin
					if (wr_col_q == COL_AW'(BYTES_PER_ROW - 1)) begin
						wr_col_q <= '0;
						wr_row_q <= wr_row_q + 1'b1;
					end else begin
						wr_col_q <= wr_col_q + 1'b1;
					end
				end
				// atoll-style number scan
				if (num_ph_q != NUM_DONE) begin
					if (is_digit) begin
						acc_q    <= acc_next;
						num_ph_q <= NUM_IN;
					end else if (num_ph_q == NUM_BEFORE && is_space) begin
						num_ph_q <= NUM_BEFORE;
					end else if (num_ph_q == NUM_BEFORE &&
						(rx_byte == CH_PLUS || rx_byte == CH_MINUS)) begin
						num_ph_q  <= NUM_IN;
						num_neg_q <= rx_byte == CH_MINUS;
					end else begin
						num_ph_q <= NUM_DONE;
					end
				end
			end
			if (cmd.cap_end) begin
				note_q   <= queue_empty && !flag_q;
				rd_row_q <= '0;
			end
			if (cmd.ld_row) begin
				rd_row_q <= rd_row_q + 1'b1;
			end
			if (cmd.ld_note) begin
				flag_q <= 1'b1;
			end
			if (cmd.ld_cmd && lookup.code == CMD_START) begin
				flag_q <= 1'b0;
			end
		end
	end

	// Picture store: byte-lane write, registered row read
	always_ff @(posedge clk) begin
		if (cmd.pay_byte && wr_on) begin
			pic_mem[wr_row_q][wr_col_q] <= rx_byte;
		end
		if (cmd.rd_row) begin
			rd_data_q <= pic_mem[rd_row_q];
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_row || cmd.ld_cmd || cmd.ld_note) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.ld_row) begin
			out_kind_q  <= KIND_ROW;
			out_row_q   <= row_word;
			out_code_q  <= '0;
			out_value_q <= '0;
			out_last_q  <= st.last_row && !note_q;
		end else if (cmd.ld_cmd) begin
			out_kind_q  <= KIND_CMD;
			out_row_q   <= '0;
			out_code_q  <= lookup.code;
			out_value_q <= num_neg_q ? ('0 - acc_q) : acc_q;
			out_last_q  <= 1'b1;
		end else if (cmd.ld_note) begin
			out_kind_q  <= KIND_NOTICE;
			out_row_q   <= '0;
			out_code_q  <= '0;
			out_value_q <= '0;
			out_last_q  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_row   = out_row_q;
	assign out_code  = out_code_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

	`HFP_ASSERT_NOW(a_load_into_free, clk, arst_n, cmd.ld_row || cmd.ld_cmd || cmd.ld_note, out_free, "result loaded over one not yet taken")
	`HFP_ASSERT_NEXT(a_notice_sets_flag, clk, arst_n, cmd.ld_note, flag_q, "underrun flag not set after notice")
	`HFP_ASSERT_NEXT(a_start_clears_flag, clk, arst_n, cmd.ld_cmd && lookup.code == CMD_START, !flag_q, "start command left underrun flag set")
	`HFP_ASSERT_NEXT(a_mid_row_not_last, clk, arst_n, cmd.ld_row && !st.last_row, !out_last_q, "inner row marked as last")

endmodule

`default_nettype wire

/* hw/rtl/hfp_ctrl.sv */
`default_nettype none

module hfp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hfp_pkg::hfp_status_t st,
	output hfp_pkg::hfp_cmd_t    cmd
);
	import hfp_pkg::*;

	typedef enum logic [3:0] {
		ST_HUNT,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_TYPE0,
		ST_TYPE1,
		ST_PAYLOAD,
		ST_CHECK0,
		ST_CHECK1,
		ST_END,
		ST_ROW_RD,
		ST_ROW_OUT,
		ST_NOTICE,
		ST_CMD
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   byte_state;
	logic   take;

	// Bytes are taken only while parsing a frame
	assign byte_state = (state_q == ST_HUNT) || (state_q == ST_LEN_HI) ||
		(state_q == ST_LEN_LO) || (state_q == ST_TYPE0) || (state_q == ST_TYPE1) ||
		(state_q == ST_PAYLOAD) || (state_q == ST_CHECK0) || (state_q == ST_CHECK1) ||
		(state_q == ST_END);
	assign in_ready = byte_state;
	assign take     = in_valid && byte_state;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_HUNT: begin
				if (take && st.start_ok) begin
					state_d = ST_LEN_HI;
				end
			end
			ST_LEN_HI: begin
				if (take) begin
					cmd.ld_len_hi = 1'b1;
					state_d       = ST_LEN_LO;
				end
			end
			ST_LEN_LO: begin
				if (take) begin
					cmd.ld_len_lo = 1'b1;
					state_d       = st.len_bad ? ST_HUNT : ST_TYPE0;
				end
			end
			ST_TYPE0: begin
				if (take) begin
					cmd.ld_type0 = 1'b1;
					state_d      = ST_TYPE1;
				end
			end
			ST_TYPE1: begin
				if (take) begin
					cmd.ld_type1 = 1'b1;
					state_d      = st.len_zero ? ST_CHECK0 : ST_PAYLOAD;
				end
			end
			ST_PAYLOAD: begin
				if (take) begin
					cmd.pay_byte = 1'b1;
					if (st.pay_last) begin
						state_d = ST_CHECK0;
					end
				end
			end
			ST_CHECK0: begin
				if (take) begin
					state_d = ST_CHECK1;
				end
			end
			ST_CHECK1: begin
				if (take) begin
					state_d = ST_END;
				end
			end
			ST_END: begin
				if (take) begin
					cmd.cap_end = 1'b1;
					if (st.end_ok && st.pic_ok) begin
						state_d = ST_ROW_RD;
					end else if (st.end_ok && st.cmd_ok) begin
						state_d = ST_CMD;
					end else begin
						state_d = ST_HUNT;
					end
				end
			end
			ST_ROW_RD: begin
				cmd.rd_row = 1'b1;
				state_d    = ST_ROW_OUT;
			end
			ST_ROW_OUT: begin
				if (st.out_free) begin
					cmd.ld_row = 1'b1;
					if (!st.last_row) begin
						state_d = ST_ROW_RD;
					end else if (st.note_due) begin
						state_d = ST_NOTICE;
					end else begin
						state_d = ST_HUNT;
					end
				end
			end
			ST_NOTICE: begin
				if (st.out_free) begin
					cmd.ld_note = 1'b1;
					state_d     = ST_HUNT;
				end
			end
			ST_CMD: begin
				if (st.out_free) begin
					cmd.ld_cmd = 1'b1;
					state_d    = ST_HUNT;
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire
